FILE: rtl/xtws_pkg.sv
// xtws_pkg: shared types, constants and lookup functions for the X-ray tube
// warmup sequencer. No dependencies; imported by xray_tube_warmup_sequencer,
// xtws_checker and tb.
package xtws_pkg;

	// Field widths
	localparam int OP_W     = 2;
	localparam int DAYS_W   = 16;
	localparam int FLAGS_W  = 7;
	localparam int KV_W     = 7;
	localparam int MA_W     = 7;
	localparam int STEP_W   = 4;
	localparam int STATUS_W = 3;
	localparam int FCODE_W  = 3;
	localparam int HOLD_W   = 8;
	localparam int SECS_W   = 9;
	localparam int DELAY_W  = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Sequence constants
	localparam logic [STEP_W-1:0]  STEP_COUNT        = 4'd10;
	localparam logic [DELAY_W-1:0] START_DELAY_TICKS = 2'd2;
	localparam logic [HOLD_W-1:0]  SAMPLE_SAT        = 8'd255;
	localparam logic [STEP_W-1:0]  SETPOINT_LAST     = 4'd9;

	// Configuration reset values
	localparam logic [HOLD_W-1:0] HOLDOFF_RST    = 8'd20;
	localparam logic [DAYS_W-1:0] LONG_DAYS_RST  = 16'd90;
	localparam logic [DAYS_W-1:0] MID_DAYS_RST   = 16'd30;
	localparam logic [DAYS_W-1:0] SHORT_DAYS_RST = 16'd2;
	localparam logic [SECS_W-1:0] LONG_SECS_RST  = 9'd300;
	localparam logic [SECS_W-1:0] MID_SECS_RST   = 9'd60;
	localparam logic [SECS_W-1:0] SHORT_SECS_RST = 9'd30;
	localparam logic [SECS_W-1:0] BASE_SECS_RST  = 9'd10;

	typedef enum logic [OP_W-1:0] {
		OP_START  = 2'd0,
		OP_TICK   = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_EXIT   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		PH_IDLE  = 3'd0,
		PH_RUN   = 3'd1,
		PH_DONE  = 3'd2,
		PH_FAULT = 3'd3,
		PH_STOP  = 3'd4
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HOLDOFF    = 3'd0,
		CFG_LONG_DAYS  = 3'd1,
		CFG_MID_DAYS   = 3'd2,
		CFG_SHORT_DAYS = 3'd3,
		CFG_LONG_SECS  = 3'd4,
		CFG_MID_SECS   = 3'd5,
		CFG_SHORT_SECS = 3'd6,
		CFG_BASE_SECS  = 3'd7
	} cfg_reg_t;

	localparam logic [KV_W-1:0] KV_TABLE [10] = '{
		7'd40, 7'd45, 7'd50, 7'd55, 7'd60, 7'd65, 7'd70, 7'd70, 7'd75, 7'd80
	};
	localparam logic [MA_W-1:0] MA_TABLE [10] = '{
		7'd25, 7'd40, 7'd55, 7'd70, 7'd85, 7'd100, 7'd115, 7'd125, 7'd125, 7'd125
	};

	// Highest set flag wins; open interlock (bit 6) is code 7.
	function automatic logic [FCODE_W-1:0] fault_code_of(input logic [FLAGS_W-1:0] flags);
		logic [FCODE_W-1:0] code;
		code = '0;
		for (int b = 0; b < FLAGS_W; b++) begin
			if (flags[b]) code = FCODE_W'(b + 1);
		end
		return code;
	endfunction

	// Table row for a step; steps past the last row hold the final setpoint.
	function automatic logic [STEP_W-1:0] setpoint_row(input logic [STEP_W-1:0] step);
		return (step > SETPOINT_LAST) ? SETPOINT_LAST : step;
	endfunction

endpackage

FILE: rtl/xray_tube_warmup_sequencer.sv
// xray_tube_warmup_sequencer: top level of the X-ray tube warmup sequencer.
// Depends on xtws_pkg (types, setpoint tables, fault priority function).
//
//  channel | dir | handshake           | beat content
//  --------+-----+---------------------+------------------------------------------
//  in      | in  | in_valid/in_ready   | operation, idle_days, fault_flags
//  out     | out | out_valid/out_ready | xray_on, set_kv, set_ma_centi, step_number,
//          |     |                     | run_status, fault_code, lamp_*, warmed_up
//  cfg     | in  | cfg_write_en        | cfg_index, cfg_data (no wait, no read-back)
//
// Rate: one input beat per clock while the output does not stall. A beat is
// captured in the _s1 register, the state update and result decode work
// combinationally on it, and the result is loaded into the output register.
// Reset (arst_n low, async) puts the sequencer idle with reset config values.
// Stalls: while out_ready is low the output register holds; the _s1 stage
// still takes one more beat, then in_ready drops until the output drains.
module xray_tube_warmup_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	// input beats
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [xtws_pkg::OP_W-1:0]      operation,
	input  logic [xtws_pkg::DAYS_W-1:0]    idle_days,
	input  logic [xtws_pkg::FLAGS_W-1:0]   fault_flags,
	// result beats
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           xray_on,
	output logic [xtws_pkg::KV_W-1:0]      set_kv,
	output logic [xtws_pkg::MA_W-1:0]      set_ma_centi,
	output logic [xtws_pkg::STEP_W-1:0]    step_number,
	output logic [xtws_pkg::STATUS_W-1:0]  run_status,
	output logic [xtws_pkg::FCODE_W-1:0]   fault_code,
	output logic                           lamp_red,
	output logic                           lamp_yellow,
	output logic                           warmed_up,
	// configuration writes
	input  logic                           cfg_write_en,
	input  logic [xtws_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [xtws_pkg::CFG_DATA_W-1:0] cfg_data
);
	import xtws_pkg::*;

	// ---------------- configuration registers ----------------
	logic [HOLD_W-1:0] holdoff_q;
	logic [DAYS_W-1:0] long_days_q, mid_days_q, short_days_q;
	logic [SECS_W-1:0] long_secs_q, mid_secs_q, short_secs_q, base_secs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_q    <= HOLDOFF_RST;
			long_days_q  <= LONG_DAYS_RST;
			mid_days_q   <= MID_DAYS_RST;
			short_days_q <= SHORT_DAYS_RST;
			long_secs_q  <= LONG_SECS_RST;
			mid_secs_q   <= MID_SECS_RST;
			short_secs_q <= SHORT_SECS_RST;
			base_secs_q  <= BASE_SECS_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_HOLDOFF:    holdoff_q    <= cfg_data[HOLD_W-1:0];
				CFG_LONG_DAYS:  long_days_q  <= cfg_data[DAYS_W-1:0];
				CFG_MID_DAYS:   mid_days_q   <= cfg_data[DAYS_W-1:0];
				CFG_SHORT_DAYS: short_days_q <= cfg_data[DAYS_W-1:0];
				CFG_LONG_SECS:  long_secs_q  <= cfg_data[SECS_W-1:0];
				CFG_MID_SECS:   mid_secs_q   <= cfg_data[SECS_W-1:0];
				CFG_SHORT_SECS: short_secs_q <= cfg_data[SECS_W-1:0];
				CFG_BASE_SECS:  base_secs_q  <= cfg_data[SECS_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- input stage ----------------
	logic                valid_s1;
	op_t                 op_s1;
	logic [DAYS_W-1:0]   days_s1;
	logic [FLAGS_W-1:0]  flags_s1;
	logic                out_valid_q;
	logic                advance;   // s1 beat is processed this cycle

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= op_t'(operation);
			days_s1  <= idle_days;
			flags_s1 <= fault_flags;
		end
	end

	// ---------------- sequencer state ----------------
	phase_t             phase_q, phase_d;
	logic [STEP_W-1:0]  step_q, step_d;
	logic [SECS_W-1:0]  sec_cnt_q, sec_cnt_d;
	logic [SECS_W-1:0]  step_secs_q, step_secs_d;
	logic [DELAY_W-1:0] delay_q, delay_d;
	logic [HOLD_W-1:0]  samples_q, samples_d;
	logic               red_q, red_d;
	logic               success_q, success_d;
	logic [FCODE_W-1:0] fault_q, fault_d;

	logic [FCODE_W-1:0] sample_code;
	logic [SECS_W-1:0]  sec_inc;
	logic [STEP_W-1:0]  step_inc;

	assign sample_code = fault_code_of(flags_s1);
	assign sec_inc     = sec_cnt_q + 1'b1;   // wraps at 9 bits
	assign step_inc    = step_q + 1'b1;

	always_comb begin
		phase_d     = phase_q;
		step_d      = step_q;
		sec_cnt_d   = sec_cnt_q;
		step_secs_d = step_secs_q;
		delay_d     = delay_q;
		samples_d   = samples_q;
		red_d       = red_q;
		success_d   = success_q;
		fault_d     = fault_q;

		if (op_s1 == OP_START) begin
			// restart from scratch, also when already running
			if (days_s1 > long_days_q)       step_secs_d = long_secs_q;
			else if (days_s1 > mid_days_q)   step_secs_d = mid_secs_q;
			else if (days_s1 > short_days_q) step_secs_d = short_secs_q;
			else                             step_secs_d = base_secs_q;
			phase_d   = PH_RUN;
			step_d    = '0;
			sec_cnt_d = '0;
			delay_d   = START_DELAY_TICKS;
			samples_d = '0;
			red_d     = 1'b1;
			success_d = 1'b0;
			fault_d   = '0;
		end else if (phase_q == PH_RUN) begin
			unique case (op_s1)
				OP_TICK: begin
					red_d = !red_q;
					if (delay_q != '0) begin
						delay_d = delay_q - 1'b1;
					end else if (sec_inc >= step_secs_q) begin
						sec_cnt_d = '0;
						step_d    = step_inc;
						if (step_inc >= STEP_COUNT) begin
							success_d = 1'b1;
							phase_d   = PH_DONE;
							red_d     = 1'b0;
						end
					end else begin
						sec_cnt_d = sec_inc;
					end
				end
				OP_SAMPLE: begin
					if (samples_q != SAMPLE_SAT) samples_d = samples_q + 1'b1;
					if (sample_code != '0 && samples_d >= holdoff_q) begin
						fault_d = sample_code;
						phase_d = PH_FAULT;
						red_d   = 1'b0;
					end
				end
				OP_EXIT: begin
					phase_d = PH_STOP;
					red_d   = 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			step_q      <= '0;
			sec_cnt_q   <= '0;
			step_secs_q <= BASE_SECS_RST;
			delay_q     <= '0;
			samples_q   <= '0;
			red_q       <= 1'b0;
			success_q   <= 1'b0;
			fault_q     <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			step_q      <= step_d;
			sec_cnt_q   <= sec_cnt_d;
			step_secs_q <= step_secs_d;
			delay_q     <= delay_d;
			samples_q   <= samples_d;
			red_q       <= red_d;
			success_q   <= success_d;
			fault_q     <= fault_d;
		end
	end

	// ---------------- result register ----------------
	logic              on_d;
	logic [STEP_W-1:0] row_d;

	assign on_d  = (phase_d == PH_RUN);
	assign row_d = setpoint_row(step_d);

	logic                xray_on_q, lamp_red_q, lamp_yellow_q, warmed_up_q;
	logic [KV_W-1:0]     set_kv_q;
	logic [MA_W-1:0]     set_ma_q;
	logic [STEP_W-1:0]   step_num_q;
	logic [STATUS_W-1:0] status_q;
	logic [FCODE_W-1:0]  fcode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			xray_on_q     <= on_d;
			set_kv_q      <= on_d ? KV_TABLE[row_d] : '0;
			set_ma_q      <= on_d ? MA_TABLE[row_d] : '0;
			step_num_q    <= step_d;
			status_q      <= phase_d;
			fcode_q       <= (phase_d == PH_FAULT) ? fault_d : '0;
			lamp_red_q    <= on_d && red_d;
			lamp_yellow_q <= !on_d;
			warmed_up_q   <= success_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign xray_on      = xray_on_q;
	assign set_kv       = set_kv_q;
	assign set_ma_centi = set_ma_q;
	assign step_number  = step_num_q;
	assign run_status   = status_q;
	assign fault_code   = fcode_q;
	assign lamp_red     = lamp_red_q;
	assign lamp_yellow  = lamp_yellow_q;
	assign warmed_up    = warmed_up_q;

endmodule

FILE: rtl/xtws_checker.sv
// xtws_checker: port-level assertions for xray_tube_warmup_sequencer, plus
// the bind that attaches it. Depends on xtws_pkg and the top level.
module xtws_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            xray_on,
	input logic [xtws_pkg::KV_W-1:0]       set_kv,
	input logic [xtws_pkg::MA_W-1:0]       set_ma_centi,
	input logic [xtws_pkg::STATUS_W-1:0]   run_status,
	input logic [xtws_pkg::FCODE_W-1:0]    fault_code,
	input logic                            lamp_red,
	input logic                            lamp_yellow
);
	import xtws_pkg::*;

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(run_status) && $stable(set_kv))
		else $error("result beat changed while stalled");

	// tube enable and yellow lamp are complementary and track the run status
	a_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (xray_on != lamp_yellow) && (xray_on == (run_status == PH_RUN)))
		else $error("xray_on, lamp_yellow and run_status disagree");

	// tube off means zero setpoints and dark red lamp
	a_off_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !xray_on |-> set_kv == '0 && set_ma_centi == '0 && !lamp_red)
		else $error("setpoint or red lamp active with tube off");

	// a fault code only shows with a fault abort, and an abort carries one
	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fault_code != '0) == (run_status == PH_FAULT))
		else $error("fault_code inconsistent with run_status");

endmodule

bind xray_tube_warmup_sequencer xtws_checker u_xtws_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.xray_on      (xray_on),
	.set_kv       (set_kv),
	.set_ma_centi (set_ma_centi),
	.run_status   (run_status),
	.fault_code   (fault_code),
	.lamp_red     (lamp_red),
	.lamp_yellow  (lamp_yellow)
);

FILE: tb/tb.sv
// tb: self-checking bench for xray_tube_warmup_sequencer.
// Depends on xtws_pkg (port widths, op/phase/register enums, sequence constants)
// and the sequencer RTL; holds its own copy of the warmup behavior for prediction.
module tb;
	import xtws_pkg::*;

	// One input beat as presented on the pins.
	typedef struct packed {
		op_t             op;
		logic [DAYS_W-1:0]  days;
		logic [FLAGS_W-1:0] flags;
	} cmd_t;

	// One result beat, field order matches the output ports.
	typedef struct packed {
		logic              hv_on;
		logic [KV_W-1:0]     kv;
		logic [MA_W-1:0]     ma;
		logic [STEP_W-1:0]   step;
		logic [STATUS_W-1:0] status;
		logic [FCODE_W-1:0]  fcode;
		logic              red;
		logic              yellow;
		logic              warm;
	} tube_view_t;

	// Shadow of the configuration registers.
	typedef struct {
		logic [HOLD_W-1:0] holdoff;
		logic [DAYS_W-1:0] long_days, mid_days, short_days;
		logic [SECS_W-1:0] long_secs, mid_secs, short_secs, base_secs;
	} warmup_limits_t;

	// Shadow of the sequencer state.
	typedef struct {
		phase_t             phase;
		logic [STEP_W-1:0]  step;
		logic [SECS_W-1:0]  secs;
		logic [SECS_W-1:0]  secs_per_step;
		logic [DELAY_W-1:0] delay;
		logic [HOLD_W-1:0]  samples;
		logic               red;
		logic               warm;
		logic [FCODE_W-1:0] fault;
	} warmup_state_t;

	// kV / centi-mA per step; rows past the last hold the final setpoint
	localparam logic [KV_W-1:0] KV_STEPS [10] = '{40, 45, 50, 55, 60, 65, 70, 70, 75, 80};
	localparam logic [MA_W-1:0] MA_STEPS [10] = '{25, 40, 55, 70, 85, 100, 115, 125, 125, 125};
	localparam logic [STEP_W-1:0] LAST_ROW = 4'd9;

	// Clock, reset, pins. Everything starts at a known value.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [OP_W-1:0]    operation = '0;
	logic [DAYS_W-1:0]  idle_days = '0;
	logic [FLAGS_W-1:0] fault_flags = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic xray_on, lamp_red, lamp_yellow, warmed_up;
	logic [KV_W-1:0]     set_kv;
	logic [MA_W-1:0]     set_ma_centi;
	logic [STEP_W-1:0]   step_number;
	logic [STATUS_W-1:0] run_status;
	logic [FCODE_W-1:0]  fault_code;
	logic                  cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Stimulus and scoreboard storage
	cmd_t           pending[$];      // beats waiting to be driven
	tube_view_t     results_due[$];  // predicted results, oldest first
	warmup_limits_t lim;
	warmup_state_t  tube;

	int queued_count = 0;
	int accepted_count = 0;
	int out_beats = 0;
	int mismatches = 0;
	int writes_done = 0;
	int runs_started = 0, runs_done = 0, runs_faulted = 0, runs_stopped = 0;

	// Set in the rising-edge block, read by the driver at the falling edge.
	logic in_took = 1'b0;

	int gap_left = 0, burst_left = 0;
	int pace_left = 0, pace_mode = 0;

	xray_tube_warmup_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.idle_days    (idle_days),
		.fault_flags  (fault_flags),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.xray_on      (xray_on),
		.set_kv       (set_kv),
		.set_ma_centi (set_ma_centi),
		.step_number  (step_number),
		.run_status   (run_status),
		.fault_code   (fault_code),
		.lamp_red     (lamp_red),
		.lamp_yellow  (lamp_yellow),
		.warmed_up    (warmed_up),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction: apply one accepted beat to the shadow state and return
	// what the sequencer should report afterwards.
	// ------------------------------------------------------------------
	function automatic tube_view_t advance_warmup(cmd_t c);
		tube_view_t v;
		logic [STEP_W-1:0]  row;
		logic [FCODE_W-1:0] code;
		int b;
		if (c.op == OP_START) begin
			// thresholds are strict "greater than", checked longest first
			if (c.days > lim.long_days) tube.secs_per_step = lim.long_secs;
			else if (c.days > lim.mid_days) tube.secs_per_step = lim.mid_secs;
			else if (c.days > lim.short_days) tube.secs_per_step = lim.short_secs;
			else tube.secs_per_step = lim.base_secs;
			tube.phase = PH_RUN;
			tube.step = '0;
			tube.secs = '0;
			tube.delay = START_DELAY_TICKS;
			tube.samples = '0;
			tube.red = 1'b1;
			tube.warm = 1'b0;
			tube.fault = '0;
			runs_started++;
		end else if (tube.phase == PH_RUN) begin
			case (c.op)
				OP_TICK: begin
					tube.red = ~tube.red;
					if (tube.delay != '0) begin
						tube.delay = tube.delay - 1'b1;
					end else begin
						// zero step time behaves like one: every counting tick steps
						tube.secs = tube.secs + 1'b1;
						if (tube.secs >= tube.secs_per_step) begin
							tube.secs = '0;
							tube.step = tube.step + 1'b1;
							if (tube.step >= STEP_COUNT) begin
								tube.warm = 1'b1;
								tube.phase = PH_DONE;
								tube.red = 1'b0;
								runs_done++;
							end
						end
					end
				end
				OP_SAMPLE: begin
					// open interlock (top bit) outranks everything below it
					code = '0;
					for (b = FLAGS_W - 1; b >= 0 && code == '0; b--) begin
						if (c.flags[b]) code = FCODE_W'(b + 1);
					end
					if (tube.samples != 8'hFF) tube.samples = tube.samples + 1'b1;
					if (code != '0 && tube.samples >= lim.holdoff) begin
						tube.fault = code;
						tube.phase = PH_FAULT;
						tube.red = 1'b0;
						runs_faulted++;
					end
				end
				default: begin
					tube.phase = PH_STOP;
					tube.red = 1'b0;
					runs_stopped++;
				end
			endcase
		end
		row = (tube.step > LAST_ROW) ? LAST_ROW : tube.step;
		v.hv_on = (tube.phase == PH_RUN);
		v.kv = v.hv_on ? KV_STEPS[row] : '0;
		v.ma = v.hv_on ? MA_STEPS[row] : '0;
		v.step = tube.step;
		v.status = tube.phase;
		v.fcode = (tube.phase == PH_FAULT) ? tube.fault : '0;
		v.red = v.hv_on & tube.red;
		v.yellow = ~v.hv_on;
		v.warm = tube.warm;
		return v;
	endfunction

	function automatic string show(tube_view_t v);
		return $sformatf("on=%0d kv=%0d ma=%0d step=%0d status=%0d fault=%0d red=%0d yel=%0d warm=%0d",
			v.hv_on, v.kv, v.ma, v.step, v.status, v.fcode, v.red, v.yellow, v.warm);
	endfunction

	// Names of the fields that differ; empty when the beat matches.
	function automatic string diff_fields(tube_view_t w, tube_view_t g);
		string s;
		s = "";
		if (g.hv_on !== w.hv_on) s = {s, " xray_on"};
		if (g.kv !== w.kv) s = {s, " set_kv"};
		if (g.ma !== w.ma) s = {s, " set_ma_centi"};
		if (g.step !== w.step) s = {s, " step_number"};
		if (g.status !== w.status) s = {s, " run_status"};
		if (g.fcode !== w.fcode) s = {s, " fault_code"};
		if (g.red !== w.red) s = {s, " lamp_red"};
		if (g.yellow !== w.yellow) s = {s, " lamp_yellow"};
		if (g.warm !== w.warm) s = {s, " warmed_up"};
		return s;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus building (zero time, called right after a rising edge)
	// ------------------------------------------------------------------
	function automatic void queue_cmd(op_t op, logic [DAYS_W-1:0] days,
			logic [FLAGS_W-1:0] flags);
		cmd_t c;
		c.op = op;
		c.days = days;
		c.flags = flags;
		pending.push_back(c);
		queued_count++;
	endfunction

	// Fault set whose top bit is uniform over all seven codes, lower bits random.
	function automatic logic [FLAGS_W-1:0] pick_fault();
		int k;
		k = $urandom_range(0, FLAGS_W - 1);
		return FLAGS_W'((1 << k) | ($urandom & ((1 << k) - 1)));
	endfunction

	function automatic logic [DAYS_W-1:0] pick_threshold();
		case ($urandom_range(0, 3))
			0: return DAYS_W'($urandom_range(0, 8));
			1: return DAYS_W'($urandom);
			2: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
			default: return DAYS_W'($urandom_range(0, 300));
		endcase
	endfunction

	// One warmup run with random content: start, ticks with samples mixed in,
	// then success, a fault, an exit, or simply cut off (next start restarts).
	// Returns the number of beats queued.
	function automatic int queue_run();
		logic [DAYS_W-1:0] d;
		int longest, ticks, n, ending, samples;
		case ($urandom_range(0, 5))
			0: d = DAYS_W'($urandom);
			1: d = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
			// land on or just past each threshold
			2: d = lim.long_days + DAYS_W'($urandom_range(0, 1));
			3: d = lim.mid_days + DAYS_W'($urandom_range(0, 1));
			4: d = lim.short_days + DAYS_W'($urandom_range(0, 1));
			default: d = DAYS_W'($urandom_range(0, 10));
		endcase
		// enough ticks for the slowest tier; extra ticks after success are ignored
		longest = 1;
		if (lim.long_secs > longest) longest = lim.long_secs;
		if (lim.mid_secs > longest) longest = lim.mid_secs;
		if (lim.short_secs > longest) longest = lim.short_secs;
		if (lim.base_secs > longest) longest = lim.base_secs;
		ticks = START_DELAY_TICKS + STEP_COUNT * longest;
		ending = $urandom_range(0, 4);
		if (ending > 1) ticks = $urandom_range(0, ticks - 1);
		queue_cmd(OP_START, d, FLAGS_W'($urandom));
		n = 1;
		samples = 0;
		while (ticks > 0) begin
			if ($urandom_range(0, 3) == 0) begin
				// faults are harmless while the holdoff is not yet reached
				queue_cmd(OP_SAMPLE, DAYS_W'($urandom),
					(samples + 1 < lim.holdoff) ? FLAGS_W'($urandom) : '0);
				samples++;
			end else begin
				queue_cmd(OP_TICK, DAYS_W'($urandom), FLAGS_W'($urandom));
				ticks--;
			end
			n++;
		end
		if (ending == 2) begin
			// usually clear the holdoff first; sometimes fault early on purpose
			if ($urandom_range(0, 2) != 0) begin
				while (samples + 1 < lim.holdoff) begin
					queue_cmd(OP_SAMPLE, DAYS_W'($urandom), '0);
					samples++;
					n++;
				end
			end
			queue_cmd(OP_SAMPLE, DAYS_W'($urandom), pick_fault());
			n++;
		end else if (ending == 3) begin
			queue_cmd(OP_EXIT, DAYS_W'($urandom), FLAGS_W'($urandom));
			n++;
		end
		return n;
	endfunction

	// ------------------------------------------------------------------
	// Configuration writes, only while nothing is in flight
	// ------------------------------------------------------------------
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_HOLDOFF:    lim.holdoff = val[HOLD_W-1:0];
			CFG_LONG_DAYS:  lim.long_days = val;
			CFG_MID_DAYS:   lim.mid_days = val;
			CFG_SHORT_DAYS: lim.short_days = val;
			CFG_LONG_SECS:  lim.long_secs = val[SECS_W-1:0];
			CFG_MID_SECS:   lim.mid_secs = val[SECS_W-1:0];
			CFG_SHORT_SECS: lim.short_secs = val[SECS_W-1:0];
			default:        lim.base_secs = val[SECS_W-1:0];
		endcase
		writes_done++;
	endtask

	// Writes all eight registers; unused upper data bits carry junk.
	task automatic program_limits(logic [HOLD_W-1:0] h, logic [DAYS_W-1:0] ld,
			logic [DAYS_W-1:0] md, logic [DAYS_W-1:0] sd, logic [SECS_W-1:0] ls,
			logic [SECS_W-1:0] ms, logic [SECS_W-1:0] ss, logic [SECS_W-1:0] bs);
		write_reg(CFG_HOLDOFF, {8'($urandom), h});
		write_reg(CFG_LONG_DAYS, ld);
		write_reg(CFG_MID_DAYS, md);
		write_reg(CFG_SHORT_DAYS, sd);
		write_reg(CFG_LONG_SECS, {7'($urandom), ls});
		write_reg(CFG_MID_SECS, {7'($urandom), ms});
		write_reg(CFG_SHORT_SECS, {7'($urandom), ss});
		write_reg(CFG_BASE_SECS, {7'($urandom), bs});
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// Sender holds off until every queued beat went in and every result came
	// back, then idles to let the two-stage pipeline settle.
	task automatic drain();
		do @(negedge clk);
		while (accepted_count != queued_count || results_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Driver: bursts of beats with random gaps between them. Valid stays up
	// with a steady payload until the beat is taken.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : driver
		cmd_t c;
		if (arst_n && (!in_valid || in_took)) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending.size() != 0) begin
				c = pending.pop_front();
				in_valid <= 1'b1;
				operation <= c.op;
				idle_days <= c.days;
				fault_flags <= c.flags;
				if (burst_left > 1) begin
					burst_left <= burst_left - 1;
				end else begin
					// a third of bursts run straight into the next one
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: switches between always ready, coin flip, one in four, and
	// sparse, each held for a random stretch.
	always @(negedge clk) begin : backpressure
		if (pace_left == 0) begin
			pace_mode <= $urandom_range(0, 3);
			pace_left <= $urandom_range(16, 64);
		end else begin
			pace_left <= pace_left - 1;
		end
		case (pace_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 1) != 0);
			2: out_ready <= (pace_left % 4 == 0);
			default: out_ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	// ------------------------------------------------------------------
	// Monitor: predict on each accepted input beat, check each result beat
	// against the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		cmd_t       beat;
		tube_view_t got, want;
		string      bad;
		in_took = arst_n && in_valid && in_ready;
		if (in_took) begin
			beat.op = op_t'(operation);
			beat.days = idle_days;
			beat.flags = fault_flags;
			results_due.push_back(advance_warmup(beat));
			accepted_count++;
		end
		if (arst_n && out_valid && out_ready) begin
			got = '{xray_on, set_kv, set_ma_centi, step_number, run_status, fault_code,
				lamp_red, lamp_yellow, warmed_up};
			if (results_due.size() == 0) begin
				if (mismatches < 10)
					$display("result beat %0d with nothing pending: %s", out_beats, show(got));
				mismatches++;
			end else begin
				want = results_due.pop_front();
				bad = diff_fields(want, got);
				if (bad != "") begin
					if (mismatches < 10)
						$display("result beat %0d wrong in%s\n  expected %s\n  actual   %s",
							out_beats, bad, show(want), show(got));
					mismatches++;
				end
			end
			out_beats++;
		end
	end

	// ------------------------------------------------------------------
	// Test flow
	// ------------------------------------------------------------------
	initial begin
		int p, made;
		// shadow copies start at their reset values
		lim = '{HOLDOFF_RST, LONG_DAYS_RST, MID_DAYS_RST, SHORT_DAYS_RST,
			LONG_SECS_RST, MID_SECS_RST, SHORT_SECS_RST, BASE_SECS_RST};
		tube = '{PH_IDLE, '0, '0, 9'd10, '0, '0, 1'b0, 1'b0, '0};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, reset configuration: ops while idle change nothing, the
		// holdoff masks an early fault, restart while running, tier edges,
		// exit while running and exit after the stop.
		@(posedge clk);
		queue_cmd(OP_TICK, 16'hFFFF, 7'h7F);
		queue_cmd(OP_SAMPLE, 16'h0000, 7'h7F);
		queue_cmd(OP_START, 16'hFFFF, 7'h00);
		repeat (3) queue_cmd(OP_TICK, 16'h0000, 7'h00);
		queue_cmd(OP_SAMPLE, 16'h0000, 7'h7F);
		queue_cmd(OP_START, 16'd91, 7'h00);
		queue_cmd(OP_START, 16'd90, 7'h00);
		queue_cmd(OP_START, 16'd30, 7'h00);
		queue_cmd(OP_START, 16'd2, 7'h00);
		queue_cmd(OP_EXIT, 16'h0000, 7'h00);
		queue_cmd(OP_EXIT, 16'h0000, 7'h00);
		drain();

		// Directed, extreme settings: zero holdoff, zero step time on the
		// short tier, top threshold unreachable. Full run to success, a tick
		// after it, then a fresh start aborted by the very first fault.
		program_limits(8'd0, 16'hFFFF, 16'h8000, 16'h0000, 9'd511, 9'd1, 9'd0, 9'd2);
		@(posedge clk);
		queue_cmd(OP_START, 16'd5, 7'h00);
		repeat (13) queue_cmd(OP_TICK, 16'h0000, 7'h00);
		queue_cmd(OP_START, 16'd0, 7'h00);
		queue_cmd(OP_SAMPLE, 16'h0000, 7'h01);
		drain();

		// Largest holdoff: a fault at sample 254 must be ignored, and one after
		// the count has sat at 255 for a while must still abort (no wrap).
		program_limits(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd511, 9'd511, 9'd511, 9'd511);
		@(posedge clk);
		queue_cmd(OP_START, DAYS_W'($urandom), FLAGS_W'($urandom));
		for (p = 0; p < 264; p++) begin
			if (p % 12 == 5) queue_cmd(OP_TICK, DAYS_W'($urandom), FLAGS_W'($urandom));
			queue_cmd(OP_SAMPLE, DAYS_W'($urandom), (p == 253) ? pick_fault() : 7'h00);
		end
		queue_cmd(OP_SAMPLE, DAYS_W'($urandom), pick_fault());
		drain();

		// Random phases: fresh limits each time, short step times so runs
		// finish, stray beats between runs.
		for (p = 0; p < 6; p++) begin
			program_limits((p == 0) ? 8'd0 : 8'($urandom_range(0, 6)),
				pick_threshold(), pick_threshold(), pick_threshold(),
				9'($urandom_range(0, 4)), 9'($urandom_range(0, 4)),
				9'($urandom_range(0, 4)), 9'($urandom_range(0, 4)));
			@(posedge clk);
			made = 0;
			while (made < 35) begin
				made += queue_run();
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3))
						queue_cmd(op_t'($urandom_range(1, 3)), DAYS_W'($urandom),
							FLAGS_W'($urandom));
			end
			drain();
		end

		$display("Run covered %0d input beats and %0d register writes over 9 settings.",
			accepted_count, writes_done);
		$display("Warmups: %0d started, %0d completed, %0d fault aborts, %0d exits.",
			runs_started, runs_done, runs_faulted, runs_stopped);
		if (mismatches == 0 && results_due.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: files.f
rtl/xtws_pkg.sv
rtl/xray_tube_warmup_sequencer.sv
rtl/xtws_checker.sv
tb/tb.sv
